// ----- src/gprp_pkg.sv -----
package gprp_pkg;

  // Field widths of one grid point and one screen point
  localparam int unsigned GRID_W  = 10;
  localparam int unsigned ALT_W   = 16;
  localparam int unsigned SCR_W   = 32;

  // Register widths
  localparam int unsigned ZOOM_W  = 8;
  localparam int unsigned HSCL_W  = 16;
  localparam int unsigned TRIG_W  = 16;

  // Configuration channel
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ZOOM         = 4'd0,
    REG_HEIGHT_SCALE = 4'd1,
    REG_SIN_ALPHA    = 4'd2,
    REG_COS_ALPHA    = 4'd3,
    REG_SIN_BETA     = 4'd4,
    REG_COS_BETA     = 4'd5,
    REG_SIN_GAMMA    = 4'd6,
    REG_COS_GAMMA    = 4'd7
  } cfg_reg_e;

  typedef struct packed {
    logic        [GRID_W-1:0] grid_col;
    logic        [GRID_W-1:0] grid_row;
    logic signed [ALT_W-1:0]  altitude;
  } in_item_t;

  typedef struct packed {
    logic signed [SCR_W-1:0] screen_x;
    logic signed [SCR_W-1:0] screen_y;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] wdata;
  } cfg_write_t;

  // Register file contents as seen by the datapath
  typedef struct packed {
    logic        [ZOOM_W-1:0] zoom;
    logic        [HSCL_W-1:0] height_scale;
    logic signed [TRIG_W-1:0] sin_alpha;
    logic signed [TRIG_W-1:0] cos_alpha;
    logic signed [TRIG_W-1:0] sin_beta;
    logic signed [TRIG_W-1:0] cos_beta;
    logic signed [TRIG_W-1:0] sin_gamma;
    logic signed [TRIG_W-1:0] cos_gamma;
  } cfg_t;

endpackage

// ----- src/gprp_chan_if.sv -----
interface gprp_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- src/gprp_cfg_regs.sv -----
module gprp_cfg_regs #(
  parameter int unsigned TRIG_FRAC_BITS = 14
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  wr_valid_i,
  output logic                  wr_ready_o,
  input  gprp_pkg::cfg_write_t  wr_i,
  output gprp_pkg::cfg_t        cfg_o
);
  import gprp_pkg::*;

  // 1.0 in the trig format, wrapped to the register width
  localparam logic [TRIG_W-1:0] TRIG_ONE = TRIG_W'(32'd1 << TRIG_FRAC_BITS);

  cfg_t cfg_q;

  assign wr_ready_o = 1'b1;
  assign cfg_o      = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.zoom         <= ZOOM_W'(1);
      cfg_q.height_scale <= HSCL_W'(256);
      cfg_q.sin_alpha    <= '0;
      cfg_q.cos_alpha    <= TRIG_ONE;
      cfg_q.sin_beta     <= '0;
      cfg_q.cos_beta     <= TRIG_ONE;
      cfg_q.sin_gamma    <= '0;
      cfg_q.cos_gamma    <= TRIG_ONE;
    end else if (wr_valid_i) begin
      unique case (cfg_reg_e'(wr_i.reg_idx))
        REG_ZOOM:         cfg_q.zoom         <= wr_i.wdata[ZOOM_W-1:0];
        REG_HEIGHT_SCALE: cfg_q.height_scale <= wr_i.wdata[HSCL_W-1:0];
        REG_SIN_ALPHA:    cfg_q.sin_alpha    <= wr_i.wdata[TRIG_W-1:0];
        REG_COS_ALPHA:    cfg_q.cos_alpha    <= wr_i.wdata[TRIG_W-1:0];
        REG_SIN_BETA:     cfg_q.sin_beta     <= wr_i.wdata[TRIG_W-1:0];
        REG_COS_BETA:     cfg_q.cos_beta     <= wr_i.wdata[TRIG_W-1:0];
        REG_SIN_GAMMA:    cfg_q.sin_gamma    <= wr_i.wdata[TRIG_W-1:0];
        REG_COS_GAMMA:    cfg_q.cos_gamma    <= wr_i.wdata[TRIG_W-1:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

endmodule

// ----- src/gprp_core.sv -----
module gprp_core #(
  parameter int unsigned GRID_BITS      = 10,
  parameter int unsigned TRIG_FRAC_BITS = 14
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  gprp_pkg::cfg_t       cfg_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  gprp_pkg::in_item_t   in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output gprp_pkg::out_item_t  out_item_o
);
  import gprp_pkg::*;

  localparam int unsigned NS   = 6;
  localparam int unsigned CW   = (GRID_BITS < GRID_W) ? GRID_BITS : GRID_W;
  localparam int unsigned XW   = CW + ZOOM_W;             // col*zoom, unsigned
  localparam int unsigned HZW  = ALT_W + HSCL_W + 1;      // altitude*height_scale
  localparam int unsigned ZQW  = HZW + ZOOM_W + 1;        // Z, Q.8
  localparam int unsigned ABW  = XW + TRIG_W + 2;         // A, B
  localparam int unsigned PZW  = ZQW + TRIG_W;
  localparam int unsigned PAW  = ABW + TRIG_W;
  localparam int unsigned SA   = 2 * TRIG_FRAC_BITS - 8;
  localparam int unsigned TZW  = PZW - TRIG_FRAC_BITS;
  localparam int unsigned TAW  = PAW - SA;
  localparam int unsigned CXW  = ((TZW > TAW) ? TZW : TAW) + 1;
  localparam int unsigned PCW  = CXW + TRIG_W;
  localparam int unsigned TCW  = PCW - TRIG_FRAC_BITS;
  localparam int unsigned SYW  = ((TAW > TCW) ? TAW : TCW) + 1;
  localparam int unsigned FW   = ((PCW > PZW) ? PCW : PZW) + 1;

  localparam logic signed [FW-1:0] SAT_MAX = FW'(signed'(32'h7FFF_FFFF));
  localparam logic signed [FW-1:0] SAT_MIN = FW'(signed'(32'h8000_0000));

  // Arithmetic shift right, rounding toward zero
  function automatic logic signed [FW-1:0] shr_tz(input logic signed [FW-1:0] v,
                                                 input int unsigned s);
    logic signed [FW-1:0] bias;
    bias = v[FW-1] ? ((FW'(1) << s) - FW'(1)) : '0;
    return (v + bias) >>> s;
  endfunction

  // Q.8 to integer, clamped to the screen range
  function automatic logic signed [SCR_W-1:0] sat_q8(input logic signed [FW-1:0] v);
    logic signed [FW-1:0] t;
    t = shr_tz(v, 8);
    if (t > SAT_MAX)      return SCR_W'(SAT_MAX);
    else if (t < SAT_MIN) return SCR_W'(SAT_MIN);
    else                  return SCR_W'(t);
  endfunction

  logic [NS-1:0] vld_q;
  logic [NS-1:0] en;

  // Each stage takes new data when it is empty or the next one moves
  always_comb begin
    en[NS-1] = !vld_q[NS-1] || out_ready_i;
    for (int i = NS - 2; i >= 0; i--) begin
      en[i] = !vld_q[i] || en[i+1];
    end
  end

  assign in_ready_o = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int i = 1; i < NS; i++) begin
        if (en[i]) begin
          vld_q[i] <= vld_q[i-1];
        end
      end
    end
  end

  // Stage 1: grid scaling
  logic        [XW-1:0]  x_q, y_q;
  logic signed [HZW-1:0] hz_q;
  // Stage 2: Z and rotation about gamma
  logic signed [ZQW-1:0] zq_q;
  logic signed [ABW-1:0] a_q, b_q;
  // Stage 3: projection products
  logic signed [PZW-1:0] pzsb_q, pzcb_q;
  logic signed [PAW-1:0] pacb_q, pasb_q, pbca_q;
  // Stage 4: screen x and inner term
  logic signed [CXW-1:0] sx_q, c_q;
  logic signed [TAW-1:0] tbca_q;
  // Stage 5: inner term times sin alpha
  logic signed [PCW-1:0]   pcsa_q;
  logic signed [SCR_W-1:0] sxs_q;
  logic signed [TAW-1:0]   tbca2_q;
  // Stage 6: output register
  logic signed [SCR_W-1:0] ox_q, oy_q;

  logic        [XW-1:0]  x_d, y_d;
  logic signed [HZW-1:0] hz_d;
  logic signed [ZQW-1:0] zq_d;
  logic signed [ABW-1:0] a_d, b_d;
  logic signed [XW:0]    xs, ys;
  logic signed [CXW-1:0] sx_d, c_d;
  logic signed [TAW-1:0] tbca_d;
  logic signed [SYW-1:0] sy_d;

  always_comb begin
    x_d  = XW'(in_item_i.grid_col[CW-1:0]) * XW'(cfg_i.zoom);
    y_d  = XW'(in_item_i.grid_row[CW-1:0]) * XW'(cfg_i.zoom);
    hz_d = HZW'(in_item_i.altitude) * HZW'(signed'({1'b0, cfg_i.height_scale}));

    xs   = signed'({1'b0, x_q});
    ys   = signed'({1'b0, y_q});
    zq_d = ZQW'(hz_q) * ZQW'(signed'({1'b0, cfg_i.zoom}));
    a_d  = ABW'(xs) * ABW'(cfg_i.cos_gamma) - ABW'(ys) * ABW'(cfg_i.sin_gamma);
    b_d  = ABW'(xs) * ABW'(cfg_i.sin_gamma) + ABW'(ys) * ABW'(cfg_i.cos_gamma);

    sx_d   = CXW'(shr_tz(FW'(pzsb_q), TRIG_FRAC_BITS)) + CXW'(shr_tz(FW'(pacb_q), SA));
    c_d    = CXW'(shr_tz(FW'(pzcb_q), TRIG_FRAC_BITS)) - CXW'(shr_tz(FW'(pasb_q), SA));
    tbca_d = TAW'(shr_tz(FW'(pbca_q), SA));

    sy_d   = SYW'(tbca2_q) - SYW'(shr_tz(FW'(pcsa_q), TRIG_FRAC_BITS));
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      x_q  <= x_d;
      y_q  <= y_d;
      hz_q <= hz_d;
    end
    if (en[1]) begin
      zq_q <= zq_d;
      a_q  <= a_d;
      b_q  <= b_d;
    end
    if (en[2]) begin
      pzsb_q <= PZW'(zq_q) * PZW'(cfg_i.sin_beta);
      pzcb_q <= PZW'(zq_q) * PZW'(cfg_i.cos_beta);
      pacb_q <= PAW'(a_q) * PAW'(cfg_i.cos_beta);
      pasb_q <= PAW'(a_q) * PAW'(cfg_i.sin_beta);
      pbca_q <= PAW'(b_q) * PAW'(cfg_i.cos_alpha);
    end
    if (en[3]) begin
      sx_q   <= sx_d;
      c_q    <= c_d;
      tbca_q <= tbca_d;
    end
    if (en[4]) begin
      pcsa_q  <= PCW'(c_q) * PCW'(cfg_i.sin_alpha);
      sxs_q   <= sat_q8(FW'(sx_q));
      tbca2_q <= tbca_q;
    end
    if (en[5]) begin
      ox_q <= sxs_q;
      oy_q <= sat_q8(FW'(sy_d));
    end
  end

  assign out_valid_o         = vld_q[NS-1];
  assign out_item_o.screen_x = ox_q;
  assign out_item_o.screen_y = oy_q;

endmodule

// ----- src/grid_point_rotate_project.sv -----
// Height-map point projector. Each transfer on in_i carries one grid point
// (column, row, altitude); one transfer on out_o returns its screen
// coordinates before the screen offset. The point is scaled by zoom
// (and height_scale for altitude), rotated about gamma, then projected with
// beta and alpha. Trig registers are signed with TRIG_FRAC_BITS fraction
// bits, height_scale is unsigned Q8.8. Products are cut to Q.8 rounding
// toward zero; the final value is rounded toward zero to an integer and
// clamped to the signed 32-bit range. Only the low GRID_BITS bits of column
// and row are used.
// Throughput: one point per cycle while out_o does not stall. Latency: six
// register stages. Stages: grid scale and altitude times height_scale; Z and
// the gamma rotation; the beta/alpha products; screen x and the inner term;
// the inner term times sin alpha with screen x clamped; screen y and the
// output register.
// Every stage holds its item under backpressure and refills as soon as the
// stage ahead moves.
// Configuration: cfg_i is always ready. Index 0 zoom, 1 height_scale,
// 2..7 sin/cos of alpha, beta, gamma; other indices are ignored. Write only
// while no point is in flight.
module grid_point_rotate_project #(
  parameter int unsigned GRID_BITS      = 10,
  parameter int unsigned TRIG_FRAC_BITS = 14
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  gprp_chan_if.sink   cfg_i,
  gprp_chan_if.sink   in_i,
  gprp_chan_if.source out_o
);
  import gprp_pkg::*;

  cfg_t      cfg;
  out_item_t out_item;

  // Register file
  gprp_cfg_regs #(
    .TRIG_FRAC_BITS(TRIG_FRAC_BITS)
  ) u_cfg_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (cfg_i.valid),
    .wr_ready_o (cfg_i.ready),
    .wr_i       (cfg_i.data),
    .cfg_o      (cfg)
  );

  // Six-stage projection pipeline
  gprp_core #(
    .GRID_BITS      (GRID_BITS),
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .in_item_i   (in_i.data),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_item_o  (out_item)
  );

  assign out_o.data = out_item;

endmodule
